/* design/lsbe_pkg.sv */
// Shared types, codes and lookup tables for the light sensor brightness estimator.
package lsbe_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LUT_IDX_W  = 4;
    localparam int LUT_LAST   = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_CEIL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_FLOOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LUX_CEIL     = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDIV,
        S_RWAIT,
        S_SEG,
        S_MUL,
        S_IDIV,
        S_IWAIT,
        S_ILLUM,
        S_BMUL,
        S_BDIV,
        S_BWAIT,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIV_RATIO,
        DIV_INTERP,
        DIV_BRIGHT
    } div_sel_t;

    typedef struct packed {
        logic     load_filter;
        logic     div_start;
        div_sel_t div_sel;
        logic     seg_load;
        logic     mul_load;
        logic     illum_load;
        logic     bmul_load;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } status_t;

    function automatic logic [15:0] lut_x(input logic [LUT_IDX_W-1:0] k);
        logic [15:0] v;
        unique case (k)
            4'd0:    v = 16'd0;
            4'd1:    v = 16'd21;
            4'd2:    v = 16'd64;
            4'd3:    v = 16'd106;
            4'd4:    v = 16'd192;
            4'd5:    v = 16'd448;
            4'd6:    v = 16'd960;
            4'd7:    v = 16'd1984;
            4'd8:    v = 16'd4032;
            4'd9:    v = 16'd8128;
            4'd10:   v = 16'd16320;
            4'd11:   v = 16'd32704;
            4'd12:   v = 16'd65472;
            4'd13:   v = 16'd65535;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] lut_y(input logic [LUT_IDX_W-1:0] k);
        logic [15:0] v;
        unique case (k)
            4'd0:    v = 16'd0;
            4'd1:    v = 16'd3;
            4'd2:    v = 16'd13;
            4'd3:    v = 16'd26;
            4'd4:    v = 16'd60;
            4'd5:    v = 16'd202;
            4'd6:    v = 16'd599;
            4'd7:    v = 16'd1689;
            4'd8:    v = 16'd4652;
            4'd9:    v = 16'd12665;
            4'd10:   v = 16'd34285;
            4'd11:   v = 16'd65535;
            4'd12:   v = 16'd65535;
            4'd13:   v = 16'd65535;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // first breakpoint index from 1 on whose x is not below the ratio, limited to the last one
    function automatic logic [LUT_IDX_W-1:0] lut_segment(input logic [15:0] ratio);
        logic [LUT_IDX_W-1:0] k;
        k = LUT_IDX_W'(1);
        for (int j = 1; j < LUT_LAST; j++) begin
            if (ratio > lut_x(LUT_IDX_W'(j))) begin
                k = LUT_IDX_W'(j + 1);
            end
        end
        return k;
    endfunction

endpackage

/* design/light_sensor_brightness_estimator_top.sv */
// Light sensor brightness estimator: top level joining controller and datapath.
//
// Input channel s_*: one ADC sample per beat (s_valid/s_ready). Output channel
// m_*: one beat per sample carrying illuminance (10.6 fixed point) and the
// scaled display brightness. Configuration: cfg_wr_en with cfg_index selects the
// brightness ceiling (0), the brightness floor (1) or the illuminance ceiling (2);
// other indexes are ignored. Write configuration only while the block is idle.
//
// One shared restoring divider, one quotient bit per cycle over DW bits with
// DW = max(32, ADC_BITS + FILTER_SHIFT + 7), runs three divisions per sample:
// the sensor ratio, the table interpolation and the brightness scaling.
// The result beat is loaded after the brightness division, once the output
// register is free. One sample is processed at a time and the next is accepted
// in the cycle after the result is loaded.
//
// Reset loads the register defaults, clears the filter and arms the first
// sample to load the filter directly. A finished result sits in the output
// register; the next sample is accepted and processed while it waits, and the
// block only holds in its final step if the receiver has still not taken it.
module light_sensor_brightness_estimator_top #(
    parameter int FILTER_SHIFT = 12,
    parameter int ADC_BITS     = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ADC_BITS-1:0]             s_adc_sample,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [15:0]                     m_illuminance,
    output logic [15:0]                     m_brightness,
    input  logic                            cfg_wr_en,
    input  logic [lsbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsbe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import lsbe_pkg::*;

    cmd_t    cmd;
    status_t stat;

    lsbe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    lsbe_datapath #(
        .FILTER_SHIFT (FILTER_SHIFT),
        .ADC_BITS     (ADC_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .adc_sample  (s_adc_sample),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .illuminance (m_illuminance),
        .brightness  (m_brightness)
    );

endmodule

/* design/lsbe_div.sv */
// Restoring divider, one quotient bit per cycle.
module lsbe_div #(
    parameter int DVD_W = 32,
    parameter int DVS_W = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/lsbe_datapath.sv */
// Filter, ratio, table interpolation and brightness scaling datapath.
module lsbe_datapath #(
    parameter int FILTER_SHIFT = 12,
    parameter int ADC_BITS     = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lsbe_pkg::cmd_t                    cmd,
    output lsbe_pkg::status_t                 stat,
    input  logic [ADC_BITS-1:0]               adc_sample,
    input  logic                              cfg_wr_en,
    input  logic [lsbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsbe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic [15:0]                       illuminance,
    output logic [15:0]                       brightness
);
    import lsbe_pkg::*;

    localparam int FW    = ADC_BITS + FILTER_SHIFT;
    localparam int TW    = FW + 2;
    localparam int DVD_W = (FW + 7 > 32) ? FW + 7 : 32;
    localparam int DVS_W = (FW > 16) ? FW : 16;
    localparam logic [TW-1:0] HALF = TW'(1) << (FILTER_SHIFT - 1);
    localparam logic [FW:0]   FULL = (FW + 1)'(1) << FW;

    logic [15:0]          max_bright_reg, min_bright_reg, max_illum_reg;
    logic [FW-1:0]        fv_reg, fv_next;
    logic                 first_reg;
    logic [15:0]          ratio_reg;
    logic [LUT_IDX_W-1:0] seg_reg;
    logic [31:0]          prod0_reg, prod1_reg;
    logic [15:0]          illum_reg;
    logic [31:0]          bprod_reg;
    logic [15:0]          out_illum_reg, out_bright_reg;

    logic [FW-1:0]        target;
    logic signed [TW-1:0] t_s, d_s;
    logic [FW:0]          diff;
    logic [31:0]          isum;
    logic [15:0]          x0, x1, y0, y1, dx;
    logic [15:0]          ratio_sat, clamped, b_raw, b_out;
    logic                 div_start, div_done;
    logic [DVD_W-1:0]     div_dvd, div_quo;
    logic [DVS_W-1:0]     div_dvs;

    assign target = {adc_sample, {FILTER_SHIFT{1'b0}}};
    assign t_s    = $signed({2'b00, target}) - $signed({2'b00, fv_reg}) + $signed(HALF);
    assign d_s    = t_s >>> FILTER_SHIFT;
    assign fv_next = first_reg ? target : fv_reg + d_s[FW-1:0];

    assign diff = FULL - {1'b0, fv_reg};
    assign isum = prod0_reg + prod1_reg;
    assign x0   = lut_x(seg_reg - LUT_IDX_W'(1));
    assign x1   = lut_x(seg_reg);
    assign y0   = lut_y(seg_reg - LUT_IDX_W'(1));
    assign y1   = lut_y(seg_reg);
    assign dx   = x1 - x0;

    always_comb begin
        div_dvd = '0;
        div_dvs = '0;
        unique case (cmd.div_sel)
            DIV_RATIO: begin
                div_dvd = DVD_W'({diff, 6'b000000});
                div_dvs = DVS_W'(fv_reg);
            end
            DIV_INTERP: begin
                div_dvd = DVD_W'(isum);
                div_dvs = DVS_W'(dx);
            end
            DIV_BRIGHT: begin
                div_dvd = DVD_W'(bprod_reg);
                div_dvs = DVS_W'(max_illum_reg);
            end
            default: begin
                div_dvd = '0;
                div_dvs = '0;
            end
        endcase
    end

    assign div_start = cmd.div_start;

    lsbe_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign stat.div_done = div_done;

    assign ratio_sat = (|div_quo[DVD_W-1:16]) ? 16'hFFFF : div_quo[15:0];
    assign clamped   = (illum_reg > max_illum_reg) ? max_illum_reg : illum_reg;
    assign b_raw     = (max_illum_reg == 16'd0) ? max_bright_reg : div_quo[15:0];
    assign b_out     = (b_raw < min_bright_reg) ? min_bright_reg : b_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bright_reg <= 16'hFFFF;
            min_bright_reg <= 16'h0000;
            max_illum_reg  <= 16'hFFFF;
            fv_reg         <= '0;
            first_reg      <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_BRIGHT_CEIL:  max_bright_reg <= cfg_wdata;
                    CFG_BRIGHT_FLOOR: min_bright_reg <= cfg_wdata;
                    CFG_LUX_CEIL:     max_illum_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.load_filter) begin
                fv_reg    <= fv_next;
                first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.seg_load) begin
            ratio_reg <= ratio_sat;
            seg_reg   <= lut_segment(ratio_sat);
        end
        if (cmd.mul_load) begin
            prod0_reg <= {16'd0, y1} * {16'd0, ratio_reg - x0};
            prod1_reg <= {16'd0, y0} * {16'd0, x1 - ratio_reg};
        end
        if (cmd.illum_load) begin
            illum_reg <= (fv_reg == '0) ? 16'hFFFF : div_quo[15:0];
        end
        if (cmd.bmul_load) begin
            bprod_reg <= {16'd0, max_bright_reg} * {16'd0, clamped};
        end
        if (cmd.out_load) begin
            out_illum_reg  <= illum_reg;
            out_bright_reg <= b_out;
        end
    end

    assign illuminance = out_illum_reg;
    assign brightness  = out_bright_reg;

endmodule

/* design/lsbe_ctrl.sv */
// Sequencing state machine and handshake control for the estimator.
module lsbe_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output lsbe_pkg::cmd_t    cmd,
    input  lsbe_pkg::status_t stat
);
    import lsbe_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_RDIV;
            S_RDIV:  state_next = S_RWAIT;
            S_RWAIT: if (stat.div_done) state_next = S_SEG;
            S_SEG:   state_next = S_MUL;
            S_MUL:   state_next = S_IDIV;
            S_IDIV:  state_next = S_IWAIT;
            S_IWAIT: if (stat.div_done) state_next = S_ILLUM;
            S_ILLUM: state_next = S_BMUL;
            S_BMUL:  state_next = S_BDIV;
            S_BDIV:  state_next = S_BWAIT;
            S_BWAIT: if (stat.div_done) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.div_sel = DIV_RATIO;
        unique case (state_reg)
            S_IDLE:  cmd.load_filter = s_valid;
            S_RDIV:  cmd.div_start = 1'b1;
            S_SEG:   cmd.seg_load = 1'b1;
            S_MUL:   cmd.mul_load = 1'b1;
            S_IDIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_INTERP;
            end
            S_ILLUM: cmd.illum_load = 1'b1;
            S_BMUL:  cmd.bmul_load = 1'b1;
            S_BDIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_BRIGHT;
            end
            S_BWAIT: cmd.div_sel = DIV_BRIGHT;
            S_DONE: begin
                cmd.div_sel  = DIV_BRIGHT;
                cmd.out_load = out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        priority if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_accept_starts_ratio: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_RDIV))
        else $error("accepted beat did not start the ratio division");

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while a beat waits");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> (state_reg == S_RWAIT || state_reg == S_IWAIT
                           || state_reg == S_BWAIT))
        else $error("divider finished outside a wait state");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result beat raised outside the done state");
`endif

endmodule
